@@ src/itoa_pkg.sv @@
`default_nettype none

package itoa_pkg;

  localparam int KIND_W      = 3;
  localparam int VALUE_W     = 32;
  localparam int CHAR_W      = 8;
  localparam int MAX_RESULTS = 16;
  localparam int OCNT_W      = 4;
  localparam int PC_W        = 3;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_A     = 8'd65;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

  typedef enum logic [KIND_W-1:0] {
    KIND_UDEC = 3'd0,
    KIND_SDEC = 3'd1,
    KIND_HEX  = 3'd2,
    KIND_OCT  = 3'd3,
    KIND_BIN  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_SIGN,
    OP_DABBLE,
    OP_SKIP,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NEVER,
    C_IDLE,
    C_SIGN_BUSY,
    C_DAB_MORE,
    C_SKIP_MORE,
    C_EMIT_MORE
  } cond_e;

  typedef struct packed {
    op_e             op;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  localparam logic [PC_W-1:0] STEP_LOAD   = 3'd0;
  localparam logic [PC_W-1:0] STEP_SIGN   = 3'd1;
  localparam logic [PC_W-1:0] STEP_DABBLE = 3'd2;
  localparam logic [PC_W-1:0] STEP_SKIP   = 3'd3;
  localparam logic [PC_W-1:0] STEP_EMIT   = 3'd4;
  localparam logic [PC_W-1:0] STEP_DONE   = 3'd5;

  function automatic ctrl_t prog_word(logic [PC_W-1:0] pc);
    ctrl_t w;
    case (pc)
      STEP_LOAD:   w = '{op: OP_LOAD,   cond: C_IDLE,      target: STEP_LOAD};
      STEP_SIGN:   w = '{op: OP_SIGN,   cond: C_SIGN_BUSY, target: STEP_SIGN};
      STEP_DABBLE: w = '{op: OP_DABBLE, cond: C_DAB_MORE,  target: STEP_DABBLE};
      STEP_SKIP:   w = '{op: OP_SKIP,   cond: C_SKIP_MORE, target: STEP_SKIP};
      STEP_EMIT:   w = '{op: OP_EMIT,   cond: C_EMIT_MORE, target: STEP_EMIT};
      STEP_DONE:   w = '{op: OP_NOP,    cond: C_ALWAYS,    target: STEP_LOAD};
      default:     w = '{op: OP_NOP,    cond: C_ALWAYS,    target: STEP_LOAD};
    endcase
    return w;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(logic [3:0] d);
    logic [CHAR_W-1:0] r;
    if (d > 4'd9) begin
      r = CHAR_A + {4'b0000, d - 4'd10};
    end else begin
      r = CHAR_ZERO + {4'b0000, d};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/itoa_if.sv @@
`default_nettype none

interface itoa_in_if;
  import itoa_pkg::*;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [VALUE_W-1:0]  value;
  modport source (output valid, output kind, output value, input ready);
  modport sink (input valid, input kind, input value, output ready);
endinterface

interface itoa_out_if;
  import itoa_pkg::*;
  logic               valid;
  logic               ready;
  logic [CHAR_W-1:0]  ascii_char;
  logic               last;
  modport source (output valid, output ascii_char, output last, input ready);
  modport sink (input valid, input ascii_char, input last, output ready);
endinterface

`default_nettype wire

@@ src/integer_to_ascii_radix_formatter.sv @@
`default_nettype none

// Channel | Dir | Payload               | Role
// in_i    | in  | kind[2:0], value[31:0] | number and format kind
// out_o   | out | ascii_char[7:0], last  | one character, last on the final one
//
// An item is taken only while the sequencer sits in its load step; an item of an
// undefined kind is taken and dropped. After the load step come one sign step,
// VALUE_WIDTH double-dabble steps for the decimal kinds (a single step otherwise),
// one step per suppressed leading zero plus one, one step per character and a done
// step. Reset clears the step counter and the output register's valid flag. A stalled
// output holds the sequencer in its sign or emit step.

module integer_to_ascii_radix_formatter #(
  parameter int VALUE_WIDTH = 32,
  parameter int BIN_DIGITS  = 16
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  itoa_in_if.sink        in_i,
  itoa_out_if.source     out_o
);
  import itoa_pkg::*;

  localparam int DEC_DIG = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int HEX_DIG = (VALUE_WIDTH + 3) / 4;
  localparam int OCT_DIG = (VALUE_WIDTH + 2) / 3;
  localparam int NSLOT0  = (DEC_DIG > HEX_DIG) ? DEC_DIG : HEX_DIG;
  localparam int NSLOT1  = (NSLOT0 > OCT_DIG) ? NSLOT0 : OCT_DIG;
  localparam int NSLOT   = (NSLOT1 > BIN_DIGITS) ? NSLOT1 : BIN_DIGITS;
  localparam int DR_W    = 4 * NSLOT;
  localparam int OCT_W   = 3 * NSLOT;
  localparam int IDX_W   = $clog2(NSLOT);
  localparam int CNT_W   = $clog2(VALUE_WIDTH + 1);

  logic [PC_W-1:0]        pc_q, pc_d;
  kind_e                  kind_q, kind_d;
  logic                   neg_q, neg_d;
  logic [VALUE_WIDTH-1:0] v_q, v_d;
  logic [DR_W-1:0]        dr_q, dr_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [OCNT_W-1:0]      ocnt_q, ocnt_d;
  logic                   out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]      char_q, char_d;
  logic                   last_q, last_d;

  ctrl_t                  cw;
  logic                   acc_ok;
  logic                   out_free;
  logic                   is_dec;
  logic                   skip_cond;
  logic                   emit_last;
  logic                   jump;
  logic [3:0]             cur_digit;
  logic [63:0]            value_ext;
  logic [VALUE_WIDTH-1:0] vin;
  logic [DR_W-1:0]        vin_hex;
  logic [OCT_W-1:0]       vin_oct;
  logic [DR_W-1:0]        dr_load;
  logic [DR_W-1:0]        dr_dab;
  logic                   vin_neg;

  assign cw         = prog_word(pc_q);
  assign in_i.ready = (pc_q == STEP_LOAD);
  assign acc_ok     = in_i.valid && (in_i.kind <= KIND_BIN);
  assign out_free   = !out_valid_q || out_o.ready;
  assign is_dec     = (kind_q == KIND_UDEC) || (kind_q == KIND_SDEC);
  assign cur_digit  = dr_q[{idx_q, 2'b00} +: 4];
  assign skip_cond  = (kind_q != KIND_BIN) && (idx_q != '0) && (cur_digit == 4'd0);
  assign emit_last  = (idx_q == '0) || (ocnt_q == OCNT_W'(MAX_RESULTS - 1));

  assign value_ext = 64'(in_i.value);
  assign vin       = value_ext[VALUE_WIDTH-1:0];
  assign vin_hex   = DR_W'(vin);
  assign vin_oct   = OCT_W'(vin);
  assign vin_neg   = (in_i.kind == KIND_SDEC) && vin[VALUE_WIDTH-1];

  always_comb begin
    dr_load = '0;
    for (int j = 0; j < NSLOT; j++) begin
      case (kind_e'(in_i.kind))
        KIND_HEX: dr_load[4*j +: 4] = vin_hex[4*j +: 4];
        KIND_OCT: dr_load[4*j +: 4] = {1'b0, vin_oct[3*j +: 3]};
        KIND_BIN: dr_load[4*j +: 4] = {3'b000, vin_hex[j]};
        default:  dr_load[4*j +: 4] = 4'd0;
      endcase
    end
  end

  always_comb begin
    for (int j = 0; j < NSLOT; j++) begin
      if (dr_q[4*j +: 4] >= 4'd5) begin
        dr_dab[4*j +: 4] = dr_q[4*j +: 4] + 4'd3;
      end else begin
        dr_dab[4*j +: 4] = dr_q[4*j +: 4];
      end
    end
  end

  always_comb begin
    case (cw.cond)
      C_ALWAYS:    jump = 1'b1;
      C_NEVER:     jump = 1'b0;
      C_IDLE:      jump = !acc_ok;
      C_SIGN_BUSY: jump = neg_q && !out_free;
      C_DAB_MORE:  jump = is_dec && (cnt_q != CNT_W'(1));
      C_SKIP_MORE: jump = skip_cond;
      C_EMIT_MORE: jump = !(out_free && emit_last);
      default:     jump = 1'b0;
    endcase
    pc_d = jump ? cw.target : pc_q + PC_W'(1);
  end

  always_comb begin
    kind_d      = kind_q;
    neg_d       = neg_q;
    v_d         = v_q;
    dr_d        = dr_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    ocnt_d      = ocnt_q;
    char_d      = char_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_o.ready;
    case (cw.op)
      OP_LOAD: begin
        kind_d = kind_e'(in_i.kind);
        neg_d  = vin_neg;
        v_d    = vin_neg ? (~vin + VALUE_WIDTH'(1)) : vin;
        dr_d   = dr_load;
        cnt_d  = CNT_W'(VALUE_WIDTH);
        ocnt_d = '0;
        case (kind_e'(in_i.kind))
          KIND_HEX: idx_d = IDX_W'(HEX_DIG - 1);
          KIND_OCT: idx_d = IDX_W'(OCT_DIG - 1);
          KIND_BIN: idx_d = IDX_W'(BIN_DIGITS - 1);
          default:  idx_d = IDX_W'(DEC_DIG - 1);
        endcase
      end
      OP_SIGN: begin
        if (neg_q && out_free) begin
          out_valid_d = 1'b1;
          char_d      = CHAR_MINUS;
          last_d      = 1'b0;
          ocnt_d      = ocnt_q + OCNT_W'(1);
        end
      end
      OP_DABBLE: begin
        if (is_dec) begin
          dr_d  = {dr_dab[DR_W-2:0], v_q[VALUE_WIDTH-1]};
          v_d   = {v_q[VALUE_WIDTH-2:0], 1'b0};
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      OP_SKIP: begin
        if (skip_cond) begin
          idx_d = idx_q - IDX_W'(1);
        end
      end
      OP_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = digit_char(cur_digit);
          last_d      = emit_last;
          ocnt_d      = ocnt_q + OCNT_W'(1);
          if (!emit_last) begin
            idx_d = idx_q - IDX_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= STEP_LOAD;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    neg_q  <= neg_d;
    v_q    <= v_d;
    dr_q   <= dr_d;
    cnt_q  <= cnt_d;
    idx_q  <= idx_d;
    ocnt_q <= ocnt_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.ascii_char = char_q;
  assign out_o.last       = last_q;

`ifndef SYNTHESIS
  a_dabble_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == STEP_DABBLE && is_dec) |-> (cnt_q != '0))
    else $error("Conversion ran past the value width.");

  a_emit_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == STEP_EMIT && out_free && !emit_last) |-> (idx_q != '0))
    else $error("Digit index would wrap during emission.");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == STEP_EMIT && out_free && emit_last) |=> (pc_q == STEP_DONE && out_o.last))
    else $error("Final character did not end the number.");
`endif

endmodule

`default_nettype wire
